// ===== rtl/tfg_pkg.sv =====
// shared constants for the triangle face geometry block
`timescale 1ns / 1ps
package tfg_pkg;

  // result field widths
  localparam int OUT_W  = 16;
  localparam int AREA_W = 33;

  // quotient bits of one normal component (one integer bit, fifteen fraction bits)
  localparam int NORM_STEPS = 16;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

endpackage

// ===== rtl/tfg_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps
interface tfg_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] v0_x, v0_y, v0_z;
  logic signed [COORD_WIDTH-1:0] v1_x, v1_y, v1_z;
  logic signed [COORD_WIDTH-1:0] v2_x, v2_y, v2_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  input ready);
  modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  output ready);
endinterface

interface tfg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] centroid_x, centroid_y, centroid_z;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic        [32:0] face_area;
  logic               degenerate;

  modport source (output valid, centroid_x, centroid_y, centroid_z, normal_x, normal_y,
                  normal_z, face_area, degenerate, input ready);
  modport sink   (input valid, centroid_x, centroid_y, centroid_z, normal_x, normal_y,
                  normal_z, face_area, degenerate, output ready);
endinterface

// ===== rtl/tfg_front.sv =====
// front pipeline: edges, cross product, centroid and squared length
`timescale 1ns / 1ps
module tfg_front import tfg_pkg::*; #(
  parameter int W = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [W-1:0]     vtx_i [3][3],
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [3*OUT_W-1:0]      cen_o,
  output logic [2:0]              csgn_o,
  output logic [3*(2*W+2)-1:0]    cmag_o,
  output logic [4*W+5:0]          sum_o,
  output logic                    deg_o
);
  localparam int AW  = W + 1;
  localparam int PW  = 2 * W + 2;
  localparam int CW  = 2 * W + 3;
  localparam int MW  = 2 * W + 2;
  localparam int H   = W + 1;
  localparam int QW  = 2 * MW;
  localparam int SW  = QW + 2;
  localparam int GW  = W + 2;
  localparam int CSH = W + 4;
  localparam int KW  = W + 3;
  localparam logic [KW-1:0] RECIP = KW'((64'd1 << CSH) / 64'd3);
  localparam int NST = 6;

  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  // stage enables, a stage loads when empty or when it drains
  always_comb begin
    en[NST-1] = !v_q[NST-1] || ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end
  assign ready_o = en[0];
  assign valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: edges and vertex sums
  logic signed [AW-1:0] a_d [3], a_q [3], b_d [3], b_q [3];
  logic signed [GW-1:0] s_d [3], s_q [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      a_d[j] = AW'(vtx_i[1][j]) - AW'(vtx_i[0][j]);
      b_d[j] = AW'(vtx_i[2][j]) - AW'(vtx_i[0][j]);
      s_d[j] = GW'(vtx_i[0][j]) + GW'(vtx_i[1][j]) + GW'(vtx_i[2][j]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_q <= a_d;
      b_q <= b_d;
      s_q <= s_d;
    end
  end

  // stage 2: the edge products for the cross product and the centroid reciprocal product
  logic signed [PW-1:0] pp_d [6], pp_q [6];
  logic [GW-1:0]        gm_d [3], gm_q [3];
  logic [2:0]           gs_d, gs_q;
  logic [GW+KW-1:0]     gp_d [3], gp_q [3];
  always_comb begin
    pp_d[0] = a_q[1] * b_q[2];
    pp_d[1] = a_q[2] * b_q[1];
    pp_d[2] = a_q[2] * b_q[0];
    pp_d[3] = a_q[0] * b_q[2];
    pp_d[4] = a_q[0] * b_q[1];
    pp_d[5] = a_q[1] * b_q[0];
    for (int j = 0; j < 3; j++) begin
      gs_d[j] = s_q[j][GW-1];
      gm_d[j] = gs_d[j] ? GW'(-s_q[j]) : GW'(s_q[j]);
      gp_d[j] = (GW+KW)'(gm_d[j]) * (GW+KW)'(RECIP);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pp_q <= pp_d;
      gm_q <= gm_d;
      gs_q <= gs_d;
      gp_q <= gp_d;
    end
  end

  // stage 3: cross product and corrected, saturated centroid
  logic signed [CW-1:0]    c_d [3], c_q [3];
  logic signed [OUT_W-1:0] cen_d [3], cen3_q [3];
  logic [GW-1:0]           gq;
  logic [GW+1:0]           grem;
  logic signed [GW:0]      gval;
  always_comb begin
    c_d[0] = CW'(pp_q[0]) - CW'(pp_q[1]);
    c_d[1] = CW'(pp_q[2]) - CW'(pp_q[3]);
    c_d[2] = CW'(pp_q[4]) - CW'(pp_q[5]);
    gq   = '0;
    grem = '0;
    gval = '0;
    for (int j = 0; j < 3; j++) begin
      gq   = GW'(gp_q[j] >> CSH);
      grem = (GW+2)'(gm_q[j]) - (GW+2)'(gq) - ((GW+2)'(gq) << 1);
      if (grem >= (GW+2)'(3)) gq = gq + GW'(1);
      gval = gs_q[j] ? -$signed({1'b0, gq}) : $signed({1'b0, gq});
      if (gval > (GW+1)'(OUT_MAX))      cen_d[j] = OUT_MAX;
      else if (gval < (GW+1)'(OUT_MIN)) cen_d[j] = OUT_MIN;
      else                              cen_d[j] = OUT_W'(gval);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c_q    <= c_d;
      cen3_q <= cen_d;
    end
  end

  // stage 4: magnitudes split in halves, partial squares
  logic [MW-1:0]   m_d [3], m_q [3];
  logic [2:0]      sg_d, sg_q;
  logic [2*H-1:0]  hh_d [3], hh_q [3], hl_d [3], hl_q [3], ll_d [3], ll_q [3];
  logic signed [OUT_W-1:0] cen4_q [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sg_d[j] = c_q[j][CW-1];
      m_d[j]  = sg_d[j] ? MW'(-c_q[j]) : MW'(c_q[j]);
      hh_d[j] = (2*H)'(m_d[j][MW-1:H]) * (2*H)'(m_d[j][MW-1:H]);
      hl_d[j] = (2*H)'(m_d[j][MW-1:H]) * (2*H)'(m_d[j][H-1:0]);
      ll_d[j] = (2*H)'(m_d[j][H-1:0]) * (2*H)'(m_d[j][H-1:0]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      m_q    <= m_d;
      sg_q   <= sg_d;
      hh_q   <= hh_d;
      hl_q   <= hl_d;
      ll_q   <= ll_d;
      cen4_q <= cen3_q;
    end
  end

  // stage 5: full squares
  logic [QW-1:0] sq_d [3], sq_q [3];
  logic [MW-1:0] m5_q [3];
  logic [2:0]    sg5_q;
  logic signed [OUT_W-1:0] cen5_q [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sq_d[j] = (QW'(hh_q[j]) << (2*H)) + (QW'(hl_q[j]) << (H+1)) + QW'(ll_q[j]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      sq_q   <= sq_d;
      m5_q   <= m_q;
      sg5_q  <= sg_q;
      cen5_q <= cen4_q;
    end
  end

  // stage 6: squared length and degenerate flag
  logic [SW-1:0] sum_d, sum_q;
  logic [MW-1:0] m6_q [3];
  logic [2:0]    sg6_q;
  logic signed [OUT_W-1:0] cen6_q [3];
  logic          deg_q;
  assign sum_d = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      sum_q  <= sum_d;
      deg_q  <= (sum_d == '0);
      m6_q   <= m5_q;
      sg6_q  <= sg5_q;
      cen6_q <= cen5_q;
    end
  end

  assign sum_o  = sum_q;
  assign deg_o  = deg_q;
  assign csgn_o = sg6_q;
  assign cmag_o = {m6_q[2], m6_q[1], m6_q[0]};
  assign cen_o  = {cen6_q[2], cen6_q[1], cen6_q[0]};

endmodule

// ===== rtl/tfg_sqrt_cell.sv =====
// one root bit of the integer square root chain
`timescale 1ns / 1ps
module tfg_sqrt_cell #(
  parameter int SW   = 70,
  parameter int R    = 35,
  parameter int SIDE = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [SW-1:0]   s_i,
  input  logic [R+2:0]    rem_i,
  input  logic [R-1:0]    root_i,
  input  logic [SIDE-1:0] side_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [SW-1:0]   s_o,
  output logic [R+2:0]    rem_o,
  output logic [R-1:0]    root_o,
  output logic [SIDE-1:0] side_o
);
  logic          valid_q;
  logic [R+2:0]  rem_sh, trial;
  logic          ge;
  logic [SW-1:0] s_q;
  logic [R+2:0]  rem_q;
  logic [R-1:0]  root_q;
  logic [SIDE-1:0] side_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh = {rem_i[R:0], s_i[SW-1:SW-2]};
    trial  = (R+3)'({root_i, 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      s_q    <= s_i << 2;
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_i[R-2:0], ge};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign s_o     = s_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/tfg_div_cell.sv =====
// one quotient bit of the three normal component dividers
`timescale 1ns / 1ps
module tfg_div_cell import tfg_pkg::*; #(
  parameter int R     = 35,
  parameter bit FIRST = 1'b0,
  parameter int SIDE  = 52
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [R-1:0]         len_i,
  input  logic [3*(R+1)-1:0]   rem_i,
  input  logic [3*OUT_W-1:0]   quo_i,
  input  logic [SIDE-1:0]      side_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [R-1:0]         len_o,
  output logic [3*(R+1)-1:0]   rem_o,
  output logic [3*OUT_W-1:0]   quo_o,
  output logic [SIDE-1:0]      side_o
);
  logic                 valid_q;
  logic [R-1:0]         len_q;
  logic [3*(R+1)-1:0]   rem_d, rem_q;
  logic [3*OUT_W-1:0]   quo_d, quo_q;
  logic [SIDE-1:0]      side_q;
  logic [R:0]           rs;
  logic                 ge;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // restoring step per lane; the first step compares without a shift
  always_comb begin
    rs    = '0;
    ge    = 1'b0;
    rem_d = '0;
    quo_d = '0;
    for (int j = 0; j < 3; j++) begin
      rs = FIRST ? rem_i[j*(R+1) +: R+1] : (rem_i[j*(R+1) +: R+1] << 1);
      ge = rs >= {1'b0, len_i};
      rem_d[j*(R+1) +: R+1] = ge ? rs - {1'b0, len_i} : rs;
      quo_d[j*OUT_W +: OUT_W] = {quo_i[j*OUT_W +: OUT_W-1], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      len_q  <= len_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign len_o   = len_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/triangle_face_geometry.sv =====
// top level: triangle centroid, unit normal and area
`timescale 1ns / 1ps
// Accepts one triangle per clock cycle unless a stall backs up, and returns one result
// per triangle, in order. A triangle passes the front pipeline (edge, cross product and
// centroid arithmetic), the square root chain with one cell per root bit
// (2*COORD_WIDTH + 3 cells), sixteen divider cells that form the three normal components
// side by side, and the output register. Every stage holds its item while the next one is
// full, so a stalled result only stops the stages behind it and gaps are squeezed out.
// Degenerate triangles (zero cross product) report zero normal and area with the flag set.
module triangle_face_geometry import tfg_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tfg_in_if.sink       req_i,
  tfg_out_if.source    rsp_o
);
  localparam int W     = COORD_WIDTH;
  localparam int MW    = 2 * W + 2;
  localparam int SW    = 4 * W + 6;
  localparam int R     = SW / 2;
  localparam int HLW   = R - 1;
  localparam int SSIDE = 3 * OUT_W + 3 + 3 * MW + 1;
  localparam int DSIDE = 3 * OUT_W + 3 + 1;

  // front pipeline
  logic signed [W-1:0]  vtx [3][3];
  logic                 fr_valid, fr_ready;
  logic [3*OUT_W-1:0]   fr_cen;
  logic [2:0]           fr_sgn;
  logic [3*MW-1:0]      fr_mag;
  logic [SW-1:0]        fr_sum;
  logic                 fr_deg;

  assign vtx[0][0] = req_i.v0_x;
  assign vtx[0][1] = req_i.v0_y;
  assign vtx[0][2] = req_i.v0_z;
  assign vtx[1][0] = req_i.v1_x;
  assign vtx[1][1] = req_i.v1_y;
  assign vtx[1][2] = req_i.v1_z;
  assign vtx[2][0] = req_i.v2_x;
  assign vtx[2][1] = req_i.v2_y;
  assign vtx[2][2] = req_i.v2_z;

  tfg_front #(.W(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .vtx_i   (vtx),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .cen_o   (fr_cen),
    .csgn_o  (fr_sgn),
    .cmag_o  (fr_mag),
    .sum_o   (fr_sum),
    .deg_o   (fr_deg)
  );

  // square root chain
  logic             sq_valid [R+1];
  logic             sq_ready [R+1];
  logic [SW-1:0]    sq_s     [R+1];
  logic [R+2:0]     sq_rem   [R+1];
  logic [R-1:0]     sq_root  [R+1];
  logic [SSIDE-1:0] sq_side  [R+1];

  assign sq_valid[0] = fr_valid;
  assign fr_ready    = sq_ready[0];
  assign sq_s[0]     = fr_sum;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = {fr_cen, fr_sgn, fr_mag, fr_deg};

  for (genvar i = 0; i < R; i++) begin : g_sqrt
    tfg_sqrt_cell #(.SW(SW), .R(R), .SIDE(SSIDE)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[i]),
      .ready_o (sq_ready[i]),
      .s_i     (sq_s[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .side_i  (sq_side[i]),
      .valid_o (sq_valid[i+1]),
      .ready_i (sq_ready[i+1]),
      .s_o     (sq_s[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .side_o  (sq_side[i+1])
    );
  end

  // divider chain
  logic [3*OUT_W-1:0] sq_cen;
  logic [2:0]         sq_sgn;
  logic [3*MW-1:0]    sq_mag;
  logic               sq_deg;
  assign {sq_cen, sq_sgn, sq_mag, sq_deg} = sq_side[R];

  logic               dv_valid [NORM_STEPS+1];
  logic               dv_ready [NORM_STEPS+1];
  logic [R-1:0]       dv_len   [NORM_STEPS+1];
  logic [3*(R+1)-1:0] dv_rem   [NORM_STEPS+1];
  logic [3*OUT_W-1:0] dv_quo   [NORM_STEPS+1];
  logic [DSIDE-1:0]   dv_side  [NORM_STEPS+1];

  assign dv_valid[0] = sq_valid[R];
  assign sq_ready[R] = dv_ready[0];
  assign dv_len[0]   = sq_root[R];
  assign dv_rem[0]   = {(R+1)'(sq_mag[2*MW +: MW]), (R+1)'(sq_mag[MW +: MW]),
                        (R+1)'(sq_mag[0 +: MW])};
  assign dv_quo[0]   = '0;
  assign dv_side[0]  = {sq_cen, sq_sgn, sq_deg};

  for (genvar i = 0; i < NORM_STEPS; i++) begin : g_div
    tfg_div_cell #(.R(R), .FIRST(i == 0), .SIDE(DSIDE)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[i]),
      .ready_o (dv_ready[i]),
      .len_i   (dv_len[i]),
      .rem_i   (dv_rem[i]),
      .quo_i   (dv_quo[i]),
      .side_i  (dv_side[i]),
      .valid_o (dv_valid[i+1]),
      .ready_i (dv_ready[i+1]),
      .len_o   (dv_len[i+1]),
      .rem_o   (dv_rem[i+1]),
      .quo_o   (dv_quo[i+1]),
      .side_o  (dv_side[i+1])
    );
  end

  // normal sign and saturation, area
  logic [3*OUT_W-1:0]      dv_cen;
  logic [2:0]              dv_sgn;
  logic                    dv_deg;
  logic [OUT_W-1:0]        q;
  logic signed [OUT_W-1:0] nrm_d [3];
  logic [HLW+AREA_W-1:0]   half;
  logic [AREA_W-1:0]       area_d;

  assign {dv_cen, dv_sgn, dv_deg} = dv_side[NORM_STEPS];

  always_comb begin
    q = '0;
    for (int j = 0; j < 3; j++) begin
      q = dv_quo[NORM_STEPS][j*OUT_W +: OUT_W];
      if (dv_deg)         nrm_d[j] = '0;
      else if (dv_sgn[j]) nrm_d[j] = -$signed(q);
      else if (q[OUT_W-1]) nrm_d[j] = OUT_MAX;
      else                nrm_d[j] = $signed(q);
    end
    half = (HLW+AREA_W)'(dv_len[NORM_STEPS] >> 1);
    if (dv_deg)                               area_d = '0;
    else if (half > (HLW+AREA_W)'(AREA_MAX))  area_d = AREA_MAX;
    else                                      area_d = half[AREA_W-1:0];
  end

  // output register
  logic                    out_valid_q;
  logic                    out_en;
  logic signed [OUT_W-1:0] cen_q [3];
  logic signed [OUT_W-1:0] nrm_q [3];
  logic [AREA_W-1:0]       area_q;
  logic                    deg_q;

  assign out_en = !out_valid_q || rsp_o.ready;
  assign dv_ready[NORM_STEPS] = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= dv_valid[NORM_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      for (int j = 0; j < 3; j++) begin
        cen_q[j] <= dv_cen[j*OUT_W +: OUT_W];
      end
      nrm_q  <= nrm_d;
      area_q <= area_d;
      deg_q  <= dv_deg;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.centroid_x = cen_q[0];
  assign rsp_o.centroid_y = cen_q[1];
  assign rsp_o.centroid_z = cen_q[2];
  assign rsp_o.normal_x   = nrm_q[0];
  assign rsp_o.normal_y   = nrm_q[1];
  assign rsp_o.normal_z   = nrm_q[2];
  assign rsp_o.face_area  = area_q;
  assign rsp_o.degenerate = deg_q;

endmodule

// ===== rtl/tfg_check.sv =====
// result channel checks, bound to the top level
`timescale 1ns / 1ps
module tfg_check (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid,
  input logic               ready,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z,
  input logic        [32:0] face_area,
  input logic               degenerate
);
  // a stalled result keeps its flag, area and normal_x
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && !ready |=> valid && $stable(degenerate) && $stable(face_area)
      && $stable(normal_x))
    else $error("result changed while stalled");

  // degenerate faces carry no normal and no area
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && degenerate |-> normal_x == 16'sd0 && normal_y == 16'sd0
      && normal_z == 16'sd0 && face_area == 33'd0)
    else $error("degenerate face with nonzero normal or area");

  // a real face has a normal of unit length, so some component is nonzero
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && !degenerate |-> normal_x != 16'sd0 || normal_y != 16'sd0
      || normal_z != 16'sd0)
    else $error("zero normal on a non-degenerate face");

endmodule

bind triangle_face_geometry tfg_check u_tfg_check (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid      (rsp_o.valid),
  .ready      (rsp_o.ready),
  .normal_x   (rsp_o.normal_x),
  .normal_y   (rsp_o.normal_y),
  .normal_z   (rsp_o.normal_z),
  .face_area  (rsp_o.face_area),
  .degenerate (rsp_o.degenerate)
);

// ===== sim/triangle_face_geometry_tb.sv =====
// self-checking testbench for the triangle face geometry block
`timescale 1ns / 1ps
module triangle_face_geometry_tb import tfg_pkg::*; ();

  localparam int CW = 16;
  localparam int N_RANDOM = 1800;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
  } tri_t;

  typedef struct packed {
    logic signed [15:0] cx, cy, cz, nx, ny, nz;
    logic [32:0]        area;
    logic               degen;
  } face_t;

  // directed row: triangle plus an optional typed-in result
  typedef struct packed {
    tri_t  tri_in;
    logic  has_exp;
    face_t exp_face;
  } row_t;

  logic clk_i;
  logic rst_ni;

  tfg_in_if #(.COORD_WIDTH(CW)) req_if ();
  tfg_out_if rsp_if ();

  triangle_face_geometry #(.COORD_WIDTH(CW)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  face_t face_q[$];
  int    err_cnt = 0;
  longint cyc = 0;
  bit    stim_done;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // integer square root of a 128 bit value
  function automatic logic [63:0] isqrt128(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  // signed component over length in Q1.15, saturated
  function automatic logic signed [15:0] unit_q15(longint c, logic [63:0] len);
    logic [63:0] r;
    logic [63:0] q;
    longint      v;
    r = (c < 0) ? 64'(-c) : 64'(c);
    q = r / len;
    r = r % len;
    for (int k = 0; k < 15; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= len) begin
        r = r - len;
        q = q | 64'd1;
      end
    end
    v = (c < 0) ? -longint'(q) : longint'(q);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // centroid, normal and area of one triangle
  function automatic face_t face_of(tri_t t);
    face_t f;
    longint p[3][3];
    longint a[3], b[3], c[3], s;
    logic [127:0] sq;
    logic [63:0]  len;
    logic [15:0]  cen[3];
    logic [15:0]  nrm[3];
    p[0] = '{t.v0_x, t.v0_y, t.v0_z};
    p[1] = '{t.v1_x, t.v1_y, t.v1_z};
    p[2] = '{t.v2_x, t.v2_y, t.v2_z};
    for (int j = 0; j < 3; j++) begin
      s = (p[0][j] + p[1][j] + p[2][j]) / 3;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      cen[j] = 16'(s);
      a[j] = p[1][j] - p[0][j];
      b[j] = p[2][j] - p[0][j];
    end
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    sq = '0;
    for (int j = 0; j < 3; j++) begin
      s = (c[j] < 0) ? -c[j] : c[j];
      sq = sq + 128'(s) * 128'(s);
    end
    f.cx = cen[0];
    f.cy = cen[1];
    f.cz = cen[2];
    if (sq == '0) begin
      f.nx = '0;
      f.ny = '0;
      f.nz = '0;
      f.area = '0;
      f.degen = 1'b1;
    end else begin
      len = isqrt128(sq);
      for (int j = 0; j < 3; j++) nrm[j] = unit_q15(c[j], len);
      f.nx = nrm[0];
      f.ny = nrm[1];
      f.nz = nrm[2];
      f.area = ((len >> 1) > 64'(AREA_MAX)) ? AREA_MAX : 33'(len >> 1);
      f.degen = 1'b0;
    end
    return f;
  endfunction

  function automatic tri_t mk_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                  int c0, int c1, int c2);
    tri_t t;
    t = '{16'(a0), 16'(a1), 16'(a2), 16'(b0), 16'(b1), 16'(b2), 16'(c0), 16'(c1), 16'(c2)};
    return t;
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    int   sel;
    sel = $urandom_range(0, 9);
    t = tri_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    // small triangles around a random spot, collinear, flat-in-z and repeated points now and then
    if (sel < 3) begin
      t.v1_x = coord_t'(t.v0_x + coord_t'($urandom_range(0, 64)) - 32);
      t.v1_y = coord_t'(t.v0_y + coord_t'($urandom_range(0, 64)) - 32);
      t.v1_z = coord_t'(t.v0_z + coord_t'($urandom_range(0, 64)) - 32);
      t.v2_x = coord_t'(t.v0_x + coord_t'($urandom_range(0, 64)) - 32);
      t.v2_y = coord_t'(t.v0_y + coord_t'($urandom_range(0, 64)) - 32);
      t.v2_z = coord_t'(t.v0_z + coord_t'($urandom_range(0, 64)) - 32);
    end else if (sel == 3) begin
      t.v2_x = coord_t'(t.v0_x + 2 * (t.v1_x - t.v0_x));
      t.v2_y = coord_t'(t.v0_y + 2 * (t.v1_y - t.v0_y));
      t.v2_z = coord_t'(t.v0_z + 2 * (t.v1_z - t.v0_z));
    end else if (sel == 4) begin
      t.v1_z = t.v0_z;
      t.v2_z = t.v0_z;
    end else if (sel == 5) begin
      t.v2_x = t.v1_x;
      t.v2_y = t.v1_y;
      t.v2_z = t.v1_z;
    end
    return t;
  endfunction

  // send one triangle, bursts with random gaps
  int burst_left;
  task automatic send_tri(tri_t t);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    req_if.valid <= 1'b1;
    {req_if.v0_x, req_if.v0_y, req_if.v0_z, req_if.v1_x, req_if.v1_y, req_if.v1_z,
     req_if.v2_x, req_if.v2_y, req_if.v2_z} <= t;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    burst_left--;
  endtask

  // predictor runs on the accepted request
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      face_q.push_back(face_of({req_if.v0_x, req_if.v0_y, req_if.v0_z, req_if.v1_x,
                                req_if.v1_y, req_if.v1_z, req_if.v2_x, req_if.v2_y,
                                req_if.v2_z}));
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    face_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (face_q.size() == 0) begin
        $error("result with nothing expected");
        err_cnt++;
      end else begin
        e = face_q.pop_front();
        if (rsp_if.centroid_x !== e.cx) begin
          $error("centroid_x exp %0d got %0d", e.cx, rsp_if.centroid_x); err_cnt++;
        end
        if (rsp_if.centroid_y !== e.cy) begin
          $error("centroid_y exp %0d got %0d", e.cy, rsp_if.centroid_y); err_cnt++;
        end
        if (rsp_if.centroid_z !== e.cz) begin
          $error("centroid_z exp %0d got %0d", e.cz, rsp_if.centroid_z); err_cnt++;
        end
        if (rsp_if.normal_x !== e.nx) begin
          $error("normal_x exp %0d got %0d", e.nx, rsp_if.normal_x); err_cnt++;
        end
        if (rsp_if.normal_y !== e.ny) begin
          $error("normal_y exp %0d got %0d", e.ny, rsp_if.normal_y); err_cnt++;
        end
        if (rsp_if.normal_z !== e.nz) begin
          $error("normal_z exp %0d got %0d", e.nz, rsp_if.normal_z); err_cnt++;
        end
        if (rsp_if.face_area !== e.area) begin
          $error("face_area exp %0d got %0d", e.area, rsp_if.face_area); err_cnt++;
        end
        if (rsp_if.degenerate !== e.degen) begin
          $error("degenerate exp %0d got %0d", e.degen, rsp_if.degenerate); err_cnt++;
        end
      end
    end
  end

  // receiver stall pattern: alternating free and choppy stretches
  int stall_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_phase  <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 600;
      if (stall_phase < 200) rsp_if.ready <= 1'b1;
      else if (stall_phase < 400) rsp_if.ready <= ($urandom_range(0, 3) != 0);
      else rsp_if.ready <= ($urandom_range(0, 2) == 0);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus
  initial begin
    row_t rows[$];
    row_t r;
    face_t zf;
    burst_left = 0;
    stim_done = 0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    {req_if.v0_x, req_if.v0_y, req_if.v0_z, req_if.v1_x, req_if.v1_y, req_if.v1_z,
     req_if.v2_x, req_if.v2_y, req_if.v2_z} = '0;

    // all zero: degenerate, zero centroid
    zf = '0; zf.degen = 1'b1;
    r.tri_in = mk_tri(0,0,0, 0,0,0, 0,0,0); r.has_exp = 1; r.exp_face = zf; rows.push_back(r);
    // all at the positive extreme
    zf = '0; zf.cx = 32767; zf.cy = 32767; zf.cz = 32767; zf.degen = 1'b1;
    r.tri_in = mk_tri(32767,32767,32767, 32767,32767,32767, 32767,32767,32767);
    r.exp_face = zf; rows.push_back(r);
    // all at the negative extreme
    zf = '0; zf.cx = -32768; zf.cy = -32768; zf.cz = -32768; zf.degen = 1'b1;
    r.tri_in = mk_tri(-32768,-32768,-32768, -32768,-32768,-32768, -32768,-32768,-32768);
    r.exp_face = zf; rows.push_back(r);
    // unit triangle in the xy plane: normal +z at full length, saturated
    zf = '0; zf.nz = OUT_MAX; zf.area = 0; zf.cx = 0; zf.cy = 0;
    r.tri_in = mk_tri(0,0,0, 1,0,0, 0,1,0); r.exp_face = zf; rows.push_back(r);
    // reversed winding: normal -z
    zf.nz = OUT_MIN;
    r.tri_in = mk_tri(0,0,0, 0,1,0, 1,0,0); r.exp_face = zf; rows.push_back(r);
    // remaining rows checked by the predictor
    r.has_exp = 0; r.exp_face = '0;
    r.tri_in = mk_tri(0,0,0, 0,0,256, 256,0,0); rows.push_back(r);
    r.tri_in = mk_tri(0,0,0, 0,256,0, 0,0,256); rows.push_back(r);
    r.tri_in = mk_tri(-32768,-32768,-32768, 32767,-32768,-32768, -32768,32767,-32768);
    rows.push_back(r);
    r.tri_in = mk_tri(-32768,-32768,-32768, 32767,32767,-32768, 32767,-32768,32767);
    rows.push_back(r);
    r.tri_in = mk_tri(32767,-32768,0, -32768,32767,32767, 0,32767,-32768); rows.push_back(r);
    r.tri_in = mk_tri(1,2,3, 2,4,6, 3,6,9); rows.push_back(r);
    r.tri_in = mk_tri(-1,-1,-1, -1,-1,-1, -2,-2,-2); rows.push_back(r);
    r.tri_in = mk_tri(100,-200,300, 101,-200,300, 100,-199,301); rows.push_back(r);
    r.tri_in = mk_tri(-32768,0,0, 32767,0,0, 0,0,32767); rows.push_back(r);
    r.tri_in = mk_tri(1,1,1, 2,1,1, 1,1,1); rows.push_back(r);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      // typed-in values must agree with the predictor too
      if (rows[i].has_exp && face_of(rows[i].tri_in) !== rows[i].exp_face) begin
        $error("directed row %0d: expected value disagrees with predictor", i);
        err_cnt++;
      end
      send_tri(rows[i].tri_in);
    end
    for (int i = 0; i < N_RANDOM; i++) send_tri(rand_tri());
    req_if.valid <= 1'b0;

    while (face_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tfg_pkg.sv
rtl/tfg_if.sv
rtl/tfg_front.sv
rtl/tfg_sqrt_cell.sv
rtl/tfg_div_cell.sv
rtl/triangle_face_geometry.sv
rtl/tfg_check.sv
sim/triangle_face_geometry_tb.sv
